// ===== sv/tensor_address_generator_defines.svh =====
// Assertion macros used by the tensor address generator RTL.
`ifndef TENSOR_ADDRESS_GENERATOR_DEFINES_SVH
`define TENSOR_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TAG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TAG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tag_pkg.sv =====
// Shared types, widths and register codes for the tensor address generator.
`default_nettype none

package tag_pkg;

    localparam int ADDR_BITS   = 22;
    localparam int COUNT_BITS  = 8;
    localparam int INDEX_BITS  = 32;
    localparam int LEVELS      = 4;
    localparam int CFG_IDX_BITS = 3;
    // Write data is as wide as the widest register
    localparam int CFG_DATA_BITS = (ADDR_BITS > COUNT_BITS) ? ADDR_BITS : COUNT_BITS;
    localparam int FLAG_BITS   = 3;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_BITS + INDEX_BITS + 7) / 8) * 8;

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [INDEX_BITS-1:0] t_index;

    // Per-transfer control handed to every level cell
    typedef struct packed {
        logic start;    // start transfer accepted: reload from the start address
        logic adv;      // advance transfer accepted
    } t_cell_ctl;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_UNIT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLICE_COUNT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUBE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNIT_STRIDE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLICE_STRIDE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_STRIDE = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUBE_STRIDE  = 3'd7;

    // Reset values of the configuration registers
    localparam t_count RST_COUNT       = t_count'(1);
    localparam t_addr  RST_UNIT_STRIDE = t_addr'(1);
    localparam t_addr  RST_STRIDE      = '0;

    // Level counter is at its end when pos + 1 >= count
    function automatic logic at_end(input t_count pos, input t_count count);
        logic [COUNT_BITS:0] w_inc;
        w_inc = {1'b0, pos} + {{COUNT_BITS{1'b0}}, 1'b1};
        return w_inc >= {1'b0, count};
    endfunction

endpackage

`default_nettype wire

// ===== sv/tensor_address_generator.sv =====
// Top level: config registers, row of four level cells and output register.
// Latency: a result is valid on the cycle after its input transfer.
// Throughput: one item per cycle while the output is not stalled; the carry and
// reload chain through the four level cells is combinational.
// Reset (synchronous, active low): counts 1, unit stride 1, other strides 0,
// all counters, addresses, base and index cleared, output empty.
`default_nettype none

module tensor_address_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [tag_pkg::CFG_IDX_BITS-1:0]       i_cfg_addr,
    input  logic [tag_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [tag_pkg::IN_TDATA_W-1:0]         i_s_axis_tdata,  // start_addr
    input  logic                                   i_s_axis_tuser,  // mode
    // Output stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [tag_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,  // addr, elem_index
    output logic [tag_pkg::FLAG_BITS-1:0]          o_m_axis_tuser,  // slice/plane/cube_end
    output logic                                   o_m_axis_tlast   // last
);
    import tag_pkg::*;

    `include "tensor_address_generator_defines.svh"

    // Configuration registers
    t_count r_count  [LEVELS];
    t_addr  r_stride [LEVELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_count[k] <= RST_COUNT;
            end
            r_stride[0] <= RST_UNIT_STRIDE;
            r_stride[1] <= RST_STRIDE;
            r_stride[2] <= RST_STRIDE;
            r_stride[3] <= RST_STRIDE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_UNIT_COUNT:   r_count[0]  <= i_cfg_wdata[COUNT_BITS-1:0];
                REG_SLICE_COUNT:  r_count[1]  <= i_cfg_wdata[COUNT_BITS-1:0];
                REG_PLANE_COUNT:  r_count[2]  <= i_cfg_wdata[COUNT_BITS-1:0];
                REG_CUBE_COUNT:   r_count[3]  <= i_cfg_wdata[COUNT_BITS-1:0];
                REG_UNIT_STRIDE:  r_stride[0] <= i_cfg_wdata[ADDR_BITS-1:0];
                REG_SLICE_STRIDE: r_stride[1] <= i_cfg_wdata[ADDR_BITS-1:0];
                REG_PLANE_STRIDE: r_stride[2] <= i_cfg_wdata[ADDR_BITS-1:0];
                REG_CUBE_STRIDE:  r_stride[3] <= i_cfg_wdata[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input transfer decode
    logic      w_acc;
    t_addr     w_start_addr;
    t_cell_ctl w_ctl;
    logic      r_valid;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start_addr    = i_s_axis_tdata[ADDR_BITS-1:0];
    assign w_ctl.start     = w_acc && i_s_axis_tuser;
    assign w_ctl.adv       = w_acc && !i_s_axis_tuser;

    // Base address of the current walk
    t_addr r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (w_ctl.start) begin
            r_base <= w_start_addr;
        end
    end

    // Row of level cells: done chain runs upward, reload source runs downward
    logic  w_done     [LEVELS];
    logic  w_end_next [LEVELS];
    t_addr w_src      [LEVELS+1];
    t_addr w_addr_next[LEVELS];

    assign w_src[LEVELS] = w_ctl.start ? w_start_addr : r_base;

    for (genvar k = 0; k < LEVELS; k++) begin : g_cell
        logic  w_done_below;
        t_addr w_ofs;

        if (k == 0) begin : g_unit
            assign w_done_below = 1'b1;
            assign w_ofs        = '0;
        end else begin : g_outer
            assign w_done_below = w_done[k-1];
            assign w_ofs        = r_stride[k];
        end

        tag_level_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_count      (r_count[k]),
            .i_step       (r_stride[k]),
            .i_reload_ofs (w_ofs),
            .i_done_below (w_done_below),
            .i_src        (w_src[k+1]),
            .o_done       (w_done[k]),
            .o_src        (w_src[k]),
            .o_end_next   (w_end_next[k]),
            .o_addr_next  (w_addr_next[k])
        );
    end

    // Element index: cleared on start and on wrap, else incremented on advance
    t_index r_index;
    t_index n_index;
    logic   w_wrap;

    assign w_wrap = w_ctl.adv && w_done[LEVELS-1];

    always_comb begin
        n_index = r_index;
        if (w_ctl.start || w_wrap) begin
            n_index = '0;
        end else if (w_ctl.adv) begin
            n_index = r_index + t_index'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

    // End flags after the transfer
    logic w_se, w_pe, w_ce, w_la;

    assign w_se = w_end_next[0];
    assign w_pe = w_se && w_end_next[1];
    assign w_ce = w_pe && w_end_next[2];
    assign w_la = w_ce && w_end_next[3];

    // Output register
    t_addr                r_out_addr;
    t_index               r_out_index;
    logic [FLAG_BITS-1:0] r_out_flags;
    logic                 r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_addr  <= w_addr_next[0];
            r_out_index <= n_index;
            r_out_flags <= {w_ce, w_pe, w_se};
            r_out_last  <= w_la;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_index, r_out_addr});
    assign o_m_axis_tuser  = r_out_flags;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    `TAG_ASSERT_IMP(a_last_in_cube, r_valid && r_out_last, r_out_flags[2],
        "last item not flagged as cube end")
    `TAG_ASSERT_IMP(a_cube_in_plane, r_valid && r_out_flags[2], r_out_flags[1],
        "cube end without plane end")
    `TAG_ASSERT_IMP(a_plane_in_slice, r_valid && r_out_flags[1], r_out_flags[0],
        "plane end without slice end")
    `TAG_ASSERT_NXT(a_start_result, w_ctl.start,
        (r_out_index == '0) && (r_out_addr == $past(w_start_addr)),
        "start item did not emit base address with index zero")

endmodule

`default_nettype wire

// ===== sv/tag_level_cell.sv =====
// One level of the walk: position counter plus running start address.
`default_nettype none

module tag_level_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tag_pkg::t_cell_ctl i_ctl,
    input  tag_pkg::t_count    i_count,       // positions at this level
    input  tag_pkg::t_addr     i_step,        // added when this level steps
    input  tag_pkg::t_addr     i_reload_ofs,  // added to the source on reload
    input  logic               i_done_below,  // all lower levels at their end
    input  tag_pkg::t_addr     i_src,         // reload source from the level above
    output logic               o_done,        // this and all lower levels at end
    output tag_pkg::t_addr     o_src,         // reload source for the level below
    output logic               o_end_next,    // at end after this transfer
    output tag_pkg::t_addr     o_addr_next
);
    import tag_pkg::*;

    t_count r_pos;
    t_count n_pos;
    t_addr  r_addr;
    t_addr  n_addr;
    logic   w_at_end;
    logic   w_step;
    logic   w_reload;

    assign w_at_end = at_end(r_pos, i_count);
    assign w_step   = i_ctl.adv && i_done_below && !w_at_end;
    assign w_reload = i_ctl.start || (i_ctl.adv && i_done_below && w_at_end);

    assign o_done = i_done_below && w_at_end;
    // Stepping level hands its old start address down to the lower levels
    assign o_src  = w_step ? r_addr : i_src;

    // Next position and address
    always_comb begin
        n_pos  = r_pos;
        n_addr = r_addr;
        if (w_reload) begin
            n_pos  = '0;
            n_addr = i_src + i_reload_ofs;
        end else if (w_step) begin
            n_pos  = r_pos + t_count'(1);
            n_addr = r_addr + i_step;
        end
    end

    assign o_end_next  = at_end(n_pos, i_count);
    assign o_addr_next = n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_addr <= '0;
        end else begin
            r_pos  <= n_pos;
            r_addr <= n_addr;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the tensor address generator: scoreboard, drivers and checks.
`timescale 1ns / 1ps

module tb;
    import tag_pkg::*;

    // Item kinds carried on the input tuser
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_START   = 1'b1;

    // Walk levels, innermost first
    localparam int LVL_UNIT  = 0;
    localparam int LVL_SLICE = 1;
    localparam int LVL_PLANE = 2;
    localparam int LVL_CUBE  = 3;

    localparam int    ITEM_TARGET = 1400;
    localparam t_addr ADDR_MAX    = '1;

    typedef struct {
        t_addr  addr;
        t_index index;
        logic   slice_end;
        logic   plane_end;
        logic   cube_end;
        logic   last;
    } t_walk_result;

    // Tracks the walk state and the addresses still owed by the block
    class addr_walk_checker;
        t_count       cnt [LEVELS];
        t_addr        stride [LEVELS];
        t_count       pos [LEVELS];
        t_addr        cur_addr;
        t_addr        slice_next;
        t_addr        plane_next;
        t_addr        cube_next;
        t_addr        walk_base;
        t_index       elem_idx;
        t_walk_result pending_q [$];
        int           errors;

        function new();
            foreach (cnt[l]) begin
                cnt[l]    = t_count'(1);
                stride[l] = '0;
                pos[l]    = '0;
            end
            stride[LVL_UNIT] = t_addr'(1);
            cur_addr   = '0;
            slice_next = '0;
            plane_next = '0;
            cube_next  = '0;
            walk_base  = '0;
            elem_idx   = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_UNIT_COUNT:   cnt[LVL_UNIT]     = data[COUNT_BITS-1:0];
                REG_SLICE_COUNT:  cnt[LVL_SLICE]    = data[COUNT_BITS-1:0];
                REG_PLANE_COUNT:  cnt[LVL_PLANE]    = data[COUNT_BITS-1:0];
                REG_CUBE_COUNT:   cnt[LVL_CUBE]     = data[COUNT_BITS-1:0];
                REG_UNIT_STRIDE:  stride[LVL_UNIT]  = data[ADDR_BITS-1:0];
                REG_SLICE_STRIDE: stride[LVL_SLICE] = data[ADDR_BITS-1:0];
                REG_PLANE_STRIDE: stride[LVL_PLANE] = data[ADDR_BITS-1:0];
                REG_CUBE_STRIDE:  stride[LVL_CUBE]  = data[ADDR_BITS-1:0];
                default: ;
            endcase
        endfunction

        // A count of zero acts as one; a position past a lowered count is at its end
        function bit level_done(int lvl);
            return int'(pos[lvl]) + 1 >= int'(cnt[lvl]);
        endfunction

        function void restart(t_addr b);
            walk_base = b;
            foreach (pos[l]) pos[l] = '0;
            cur_addr   = b;
            slice_next = b + stride[LVL_SLICE];
            plane_next = b + stride[LVL_PLANE];
            cube_next  = b + stride[LVL_CUBE];
            elem_idx   = '0;
        endfunction

        // Step to the next unit; the deepest level that is not done moves
        function void step_walk();
            if (!level_done(LVL_UNIT)) begin
                pos[LVL_UNIT] = pos[LVL_UNIT] + 1'b1;
                cur_addr      = cur_addr + stride[LVL_UNIT];
            end else if (!level_done(LVL_SLICE)) begin
                pos[LVL_UNIT]  = '0;
                pos[LVL_SLICE] = pos[LVL_SLICE] + 1'b1;
                cur_addr       = slice_next;
                slice_next     = slice_next + stride[LVL_SLICE];
            end else if (!level_done(LVL_PLANE)) begin
                pos[LVL_UNIT]  = '0;
                pos[LVL_SLICE] = '0;
                pos[LVL_PLANE] = pos[LVL_PLANE] + 1'b1;
                cur_addr       = plane_next;
                slice_next     = plane_next + stride[LVL_SLICE];
                plane_next     = plane_next + stride[LVL_PLANE];
            end else if (!level_done(LVL_CUBE)) begin
                pos[LVL_UNIT]  = '0;
                pos[LVL_SLICE] = '0;
                pos[LVL_PLANE] = '0;
                pos[LVL_CUBE]  = pos[LVL_CUBE] + 1'b1;
                cur_addr       = cube_next;
                slice_next     = cube_next + stride[LVL_SLICE];
                plane_next     = cube_next + stride[LVL_PLANE];
                cube_next      = cube_next + stride[LVL_CUBE];
            end else begin
                // end of traversal: start over from the stored base
                restart(walk_base);
                return;
            end
            elem_idx = elem_idx + 1'b1;
        endfunction

        function void note_input(logic mode, t_addr a);
            t_walk_result r;
            if (mode == MODE_START) restart(a);
            else step_walk();
            r.addr      = cur_addr;
            r.index     = elem_idx;
            r.slice_end = level_done(LVL_UNIT);
            r.plane_end = r.slice_end && level_done(LVL_SLICE);
            r.cube_end  = r.plane_end && level_done(LVL_PLANE);
            r.last      = r.cube_end && level_done(LVL_CUBE);
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 100) $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_addr a, t_index ix, logic [FLAG_BITS-1:0] ends, logic lst);
            t_walk_result e;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected transfer addr=%h index=%0d", a, ix));
                return;
            end
            e = pending_q.pop_front();
            if (a !== e.addr)
                report($sformatf("addr %h, want %h", a, e.addr));
            if (ix !== e.index)
                report($sformatf("elem_index %0d, want %0d", ix, e.index));
            if (ends[0] !== e.slice_end)
                report($sformatf("slice_end %b, want %b (addr %h)", ends[0], e.slice_end, e.addr));
            if (ends[1] !== e.plane_end)
                report($sformatf("plane_end %b, want %b (addr %h)", ends[1], e.plane_end, e.addr));
            if (ends[2] !== e.cube_end)
                report($sformatf("cube_end %b, want %b (addr %h)", ends[2], e.cube_end, e.addr));
            if (lst !== e.last)
                report($sformatf("last %b, want %b (addr %h)", lst, e.last, e.addr));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_W-1:0]     i_s_axis_tdata = '0;   // start_addr
    logic                      i_s_axis_tuser = 1'b0; // mode
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    o_m_axis_tdata;        // addr, elem_index
    logic [FLAG_BITS-1:0]      o_m_axis_tuser;        // slice_end, plane_end, cube_end
    logic                      o_m_axis_tlast;        // last

    addr_walk_checker walk_chk;
    int   items_sent = 0;
    bit   tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    int   stall_left = 0;

    tensor_address_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_addr pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return ADDR_MAX;
        return t_addr'($urandom);
    endfunction

    // Small counts dominate so walks wrap; zero and the maximum show up too
    function automatic t_count pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return t_count'($urandom_range(1, 4));
        if (r < 65) return '0;
        if (r < 75) return t_count'(1);
        if (r < 85) return '1;
        return t_count'($urandom_range(0, 255));
    endfunction

    // Output sink with random stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 99) < 30) begin
            stall_left      <= pick_gap();
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            walk_chk.check_result(o_m_axis_tdata[ADDR_BITS-1:0],
                                  o_m_axis_tdata[ADDR_BITS +: INDEX_BITS],
                                  o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    task automatic hold_off(int n);
        i_s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // One input transfer, then a random gap unless sending is quiet
    task automatic send_item(logic mode, t_addr a);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {{(IN_TDATA_W-ADDR_BITS){1'b0}}, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        walk_chk.note_input(mode, a);
        items_sent++;
        if (!tx_quiet) begin
            gap = pick_gap();
            if (gap > 0) hold_off(gap);
        end
    endtask

    // Stop sending until every owed address has come out
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (walk_chk.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        walk_chk.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_shape(t_count uc, t_count sc, t_count pc, t_count cc,
                             t_addr us, t_addr ss, t_addr ps, t_addr cs);
        cfg_write(REG_UNIT_COUNT,   CFG_DATA_BITS'(uc));
        cfg_write(REG_SLICE_COUNT,  CFG_DATA_BITS'(sc));
        cfg_write(REG_PLANE_COUNT,  CFG_DATA_BITS'(pc));
        cfg_write(REG_CUBE_COUNT,   CFG_DATA_BITS'(cc));
        cfg_write(REG_UNIT_STRIDE,  CFG_DATA_BITS'(us));
        cfg_write(REG_SLICE_STRIDE, CFG_DATA_BITS'(ss));
        cfg_write(REG_PLANE_STRIDE, CFG_DATA_BITS'(ps));
        cfg_write(REG_CUBE_STRIDE,  CFG_DATA_BITS'(cs));
        cfg_close();
    endtask

    // Generous time limit
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                       n;
        bit                       write_all;
        logic [CFG_IDX_BITS-1:0]  ridx;
        logic [CFG_DATA_BITS-1:0] wdata;

        walk_chk = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Advance with no start: reset shape, every unit is the last
        send_item(MODE_ADVANCE, t_addr'($urandom));
        send_item(MODE_ADVANCE, '0);

        // 2x2x1x2 walk from the top address, strides that wrap
        wait_for_results();
        set_shape(t_count'(2), t_count'(2), t_count'(1), t_count'(2),
                  t_addr'(3), ADDR_MAX, t_addr'('h100), t_addr'('h1000));
        send_item(MODE_START, ADDR_MAX);
        repeat (8) send_item(MODE_ADVANCE, t_addr'($urandom));
        send_item(MODE_START, '0);
        repeat (2) send_item(MODE_ADVANCE, ADDR_MAX);

        // Zero counts behave as one
        wait_for_results();
        set_shape('0, t_count'(3), '0, t_count'(1),
                  t_addr'('h15), t_addr'('h400), t_addr'('h2000), '0);
        send_item(MODE_START, t_addr'($urandom));
        repeat (4) send_item(MODE_ADVANCE, '0);

        // Unit count lowered below the current position mid-walk
        wait_for_results();
        set_shape(t_count'(5), t_count'(2), t_count'(1), t_count'(1),
                  t_addr'(4), t_addr'('h40), '0, '0);
        send_item(MODE_START, t_addr'('h2AAAAA));
        repeat (3) send_item(MODE_ADVANCE, '0);
        wait_for_results();
        cfg_write(REG_UNIT_COUNT, CFG_DATA_BITS'(2));
        cfg_close();
        repeat (2) send_item(MODE_ADVANCE, t_addr'('h155555));

        // Random phases: new shape while idle, then a burst of items
        write_all = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            wait_for_results();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            for (int r = 0; r < (1 << CFG_IDX_BITS); r++) begin
                ridx = CFG_IDX_BITS'(r);
                if (write_all || $urandom_range(0, 1) == 1) begin
                    if (ridx <= REG_CUBE_COUNT) begin
                        wdata = CFG_DATA_BITS'($urandom);
                        wdata[COUNT_BITS-1:0] = pick_count();
                    end else begin
                        wdata = CFG_DATA_BITS'(pick_addr());
                    end
                    cfg_write(ridx, wdata);
                end
            end
            cfg_close();
            write_all = 1'b0;
            n = $urandom_range(40, 110);
            for (int k = 0; k < n; k++) begin
                if ((k == 0 && $urandom_range(0, 9) < 7) || $urandom_range(0, 99) < 3)
                    send_item(MODE_START, pick_addr());
                else
                    send_item(MODE_ADVANCE, t_addr'($urandom));
            end
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (walk_chk.errors == 0 && walk_chk.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
